### sv/abrw_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// abrw_pkg
// Codes, widths and shared types of the ack-bitfield reliability window.
// ----------------------------------------------------------------------------
package abrw_pkg;

  localparam int SEQ_W     = 16;
  localparam int TIME_W    = 32;
  localparam int SLOT_W    = 6;
  localparam int MASK_BITS = 16;

  typedef enum logic [1:0] {
    OP_SEND = 2'd0,
    OP_RECV = 2'd1,
    OP_TICK = 2'd2
  } op_e_t;

  typedef enum logic [1:0] {
    KIND_SEND = 2'd0,
    KIND_RECV = 2'd1,
    KIND_RETX = 2'd2
  } kind_e_t;

endpackage

### sv/abrw_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// abrw_if
// Event and result channels of the reliability window, valid/ready framed.
// ----------------------------------------------------------------------------
interface abrw_in_if
  import abrw_pkg::*;
();
  logic                valid;
  logic                ready;
  logic [1:0]          op;
  logic [TIME_W-1:0]   now;
  logic [SEQ_W-1:0]    remote_seq;
  logic [SEQ_W-1:0]    remote_ack;
  logic [MASK_BITS-1:0] remote_ack_mask;

  modport source (output valid, op, now, remote_seq, remote_ack, remote_ack_mask,
                  input ready);
  modport sink   (input valid, op, now, remote_seq, remote_ack, remote_ack_mask,
                  output ready);
endinterface

interface abrw_out_if
  import abrw_pkg::*;
();
  logic                 valid;
  logic                 ready;
  logic [1:0]           kind;
  logic [SEQ_W-1:0]     seq_out;
  logic [SLOT_W-1:0]    slot_out;
  logic                 is_new;
  logic [SEQ_W-1:0]     local_ack;
  logic [MASK_BITS-1:0] local_ack_mask;
  logic                 last;

  modport source (output valid, kind, seq_out, slot_out, is_new, local_ack,
                  local_ack_mask, last, input ready);
  modport sink   (input valid, kind, seq_out, slot_out, is_new, local_ack,
                  local_ack_mask, last, output ready);
endinterface

### sv/ack_bitfield_reliability_window_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ack_bitfield_reliability_window_top
// Sequence, acknowledgement and retransmit bookkeeping of a reliable datagram
// channel. Entry sequence and time stamp live in one synchronous memory of
// WINDOW_SIZE words; valid bits sit in flip-flops. A send is held in the
// pending register and moved into the output register once that is free, and
// the next event is accepted only after that move. A receive or a tick walks
// the whole window through the single memory read port, one entry a cycle
// while the result side does not hold back a word. The retransmit word of each
// expired entry is held back until the next expiry or the end of the walk so
// that its last flag is known.
// Events are taken one at a time; the previous result word may still wait in
// the output register while the next event is accepted.
// ----------------------------------------------------------------------------
module ack_bitfield_reliability_window_top
  import abrw_pkg::*;
#(
  parameter int WINDOW_SIZE = 32
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic [TIME_W-1:0] cfg_wdata,
  abrw_in_if.sink           in_ch,
  abrw_out_if.source        out_ch
);

  localparam int IDX_W   = $clog2(WINDOW_SIZE);
  localparam int CNT_W   = $clog2(WINDOW_SIZE + 1);
  localparam int ENTRY_W = SEQ_W + TIME_W;
  localparam logic [TIME_W-1:0] TIMEOUT_RST = 32'd100;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FINISH
  } state_t;

  // control state
  state_t                 state_r, state_nxt;
  logic [SEQ_W-1:0]       tx_seq_r, tx_seq_nxt;
  logic [IDX_W-1:0]       next_slot_r, next_slot_nxt;
  logic [WINDOW_SIZE-1:0] valid_r, valid_nxt;
  logic [SEQ_W-1:0]       newest_r, newest_nxt;
  logic [MASK_BITS-1:0]   rmask_r, rmask_nxt;
  logic                   any_r, any_nxt;
  logic [TIME_W-1:0]      timeout_r, timeout_nxt;
  logic [CNT_W-1:0]       issue_r, issue_nxt;
  logic                   eval_v_r, eval_v_nxt;
  logic                   pend_v_r, pend_v_nxt;
  logic                   out_valid_r, out_valid_nxt;

  // payload
  op_e_t                  op_r, op_nxt;
  logic [TIME_W-1:0]      now_r, now_nxt;
  logic [SEQ_W-1:0]       rack_r, rack_nxt;
  logic [MASK_BITS-1:0]   rackm_r, rackm_nxt;
  logic [IDX_W-1:0]       eval_idx_r, eval_idx_nxt;
  kind_e_t                pend_kind_r, pend_kind_nxt;
  logic [SEQ_W-1:0]       pend_seq_r, pend_seq_nxt;
  logic [SLOT_W-1:0]      pend_slot_r, pend_slot_nxt;
  logic                   pend_new_r, pend_new_nxt;
  logic [SEQ_W-1:0]       pend_ack_r, pend_ack_nxt;
  logic [MASK_BITS-1:0]   pend_mask_r, pend_mask_nxt;
  kind_e_t                out_kind_r, out_kind_nxt;
  logic [SEQ_W-1:0]       out_seq_r, out_seq_nxt;
  logic [SLOT_W-1:0]      out_slot_r, out_slot_nxt;
  logic                   out_new_r, out_new_nxt;
  logic [SEQ_W-1:0]       out_ack_r, out_ack_nxt;
  logic [MASK_BITS-1:0]   out_mask_r, out_mask_nxt;
  logic                   out_last_r, out_last_nxt;

  // window memory
  logic [ENTRY_W-1:0]     mem [WINDOW_SIZE];
  logic [ENTRY_W-1:0]     rd_data_r;
  logic                   mem_we, mem_re;
  logic [IDX_W-1:0]       mem_waddr, mem_raddr;
  logic [ENTRY_W-1:0]     mem_wdata;

  logic                   accept, out_free;

  // receive path
  logic [SEQ_W-1:0]       gap, ngap;
  logic                   fwd, late;
  logic [MASK_BITS-1:0]   shifted, fwd_bit, late_bit;
  logic [SEQ_W-1:0]       rx_newest;
  logic [MASK_BITS-1:0]   rx_mask;
  logic                   rx_fresh;

  // scan evaluation
  logic [SEQ_W-1:0]       ent_seq;
  logic [TIME_W-1:0]      ent_stamp;
  logic                   ent_valid;
  logic [SEQ_W-1:0]       agap;
  logic                   ack_hit;
  logic [TIME_W-1:0]      age;
  logic                   hit_ack, hit_tmo, stall;

  assign in_ch.ready = (state_r == ST_IDLE);
  assign accept      = in_ch.valid && in_ch.ready;
  assign out_free    = !out_valid_r || out_ch.ready;

  assign out_ch.valid          = out_valid_r;
  assign out_ch.kind           = out_kind_r;
  assign out_ch.seq_out        = out_seq_r;
  assign out_ch.slot_out       = out_slot_r;
  assign out_ch.is_new         = out_new_r;
  assign out_ch.local_ack      = out_ack_r;
  assign out_ch.local_ack_mask = out_mask_r;
  assign out_ch.last           = out_last_r;

  // Receive bookkeeping: signed distance of the arriving sequence
  always_comb begin
    gap      = in_ch.remote_seq - newest_r;
    ngap     = SEQ_W'(0) - gap;
    fwd      = !gap[SEQ_W-1] && (gap != '0);
    late     = gap[SEQ_W-1] && (ngap < SEQ_W'(MASK_BITS));
    shifted  = (gap >= SEQ_W'(MASK_BITS)) ? '0 : (rmask_r << gap[3:0]);
    fwd_bit  = (gap <= SEQ_W'(MASK_BITS)) ? (MASK_BITS'(1) << (gap[3:0] - 4'd1)) : '0;
    late_bit = MASK_BITS'(1) << (ngap[3:0] - 4'd1);
    rx_newest = newest_r;
    rx_mask   = rmask_r;
    rx_fresh  = 1'b0;
    if (!any_r) begin
      rx_newest = in_ch.remote_seq;
      rx_mask   = '0;
      rx_fresh  = 1'b1;
    end else if (fwd) begin
      rx_newest = in_ch.remote_seq;
      rx_mask   = shifted | fwd_bit;
      rx_fresh  = 1'b1;
    end else if (late && ((rmask_r & late_bit) == '0)) begin
      rx_mask   = rmask_r | late_bit;
      rx_fresh  = 1'b1;
    end
  end

  // Entry evaluation on the registered read data
  always_comb begin
    ent_seq   = rd_data_r[ENTRY_W-1:TIME_W];
    ent_stamp = rd_data_r[TIME_W-1:0];
    ent_valid = valid_r[eval_idx_r];
    agap      = rack_r - ent_seq;
    ack_hit   = (agap == '0) ||
                (!agap[SEQ_W-1] && (agap <= SEQ_W'(MASK_BITS)) &&
                 rackm_r[agap[3:0] - 4'd1]);
    age       = now_r - ent_stamp;
    hit_ack   = eval_v_r && (op_r == OP_RECV) && ent_valid && ack_hit;
    hit_tmo   = eval_v_r && (op_r == OP_TICK) && ent_valid && (age > timeout_r);
    stall     = hit_tmo && pend_v_r && !out_free;
  end

  always_comb begin
    state_nxt     = state_r;
    tx_seq_nxt    = tx_seq_r;
    next_slot_nxt = next_slot_r;
    valid_nxt     = valid_r;
    newest_nxt    = newest_r;
    rmask_nxt     = rmask_r;
    any_nxt       = any_r;
    timeout_nxt   = cfg_we ? cfg_wdata : timeout_r;
    issue_nxt     = issue_r;
    eval_v_nxt    = eval_v_r;
    pend_v_nxt    = pend_v_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    op_nxt        = op_r;
    now_nxt       = now_r;
    rack_nxt      = rack_r;
    rackm_nxt     = rackm_r;
    eval_idx_nxt  = eval_idx_r;
    pend_kind_nxt = pend_kind_r;
    pend_seq_nxt  = pend_seq_r;
    pend_slot_nxt = pend_slot_r;
    pend_new_nxt  = pend_new_r;
    pend_ack_nxt  = pend_ack_r;
    pend_mask_nxt = pend_mask_r;
    out_kind_nxt  = out_kind_r;
    out_seq_nxt   = out_seq_r;
    out_slot_nxt  = out_slot_r;
    out_new_nxt   = out_new_r;
    out_ack_nxt   = out_ack_r;
    out_mask_nxt  = out_mask_r;
    out_last_nxt  = out_last_r;
    mem_we        = 1'b0;
    mem_re        = 1'b0;
    mem_waddr     = next_slot_r;
    mem_raddr     = issue_r[IDX_W-1:0];
    mem_wdata     = {tx_seq_r, in_ch.now};

    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          case (in_ch.op)
            OP_SEND: begin
              mem_we                 = 1'b1;
              valid_nxt[next_slot_r] = 1'b1;
              tx_seq_nxt             = tx_seq_r + SEQ_W'(1);
              // slot wraps with the window and with the sequence counter
              if ((next_slot_r == IDX_W'(WINDOW_SIZE - 1)) || (tx_seq_r == '1)) begin
                next_slot_nxt = '0;
              end else begin
                next_slot_nxt = next_slot_r + IDX_W'(1);
              end
              pend_kind_nxt = KIND_SEND;
              pend_seq_nxt  = tx_seq_r;
              pend_slot_nxt = SLOT_W'(next_slot_r);
              pend_new_nxt  = 1'b0;
              pend_ack_nxt  = '0;
              pend_mask_nxt = '0;
              pend_v_nxt    = 1'b1;
              state_nxt     = ST_FINISH;
            end
            OP_RECV: begin
              newest_nxt    = rx_newest;
              rmask_nxt     = rx_mask;
              any_nxt       = 1'b1;
              pend_kind_nxt = KIND_RECV;
              pend_seq_nxt  = '0;
              pend_slot_nxt = '0;
              pend_new_nxt  = rx_fresh;
              pend_ack_nxt  = rx_newest;
              pend_mask_nxt = rx_mask;
              pend_v_nxt    = 1'b1;
              op_nxt        = OP_RECV;
              rack_nxt      = in_ch.remote_ack;
              rackm_nxt     = in_ch.remote_ack_mask;
              issue_nxt     = '0;
              eval_v_nxt    = 1'b0;
              state_nxt     = ST_SCAN;
            end
            OP_TICK: begin
              op_nxt     = OP_TICK;
              now_nxt    = in_ch.now;
              issue_nxt  = '0;
              eval_v_nxt = 1'b0;
              state_nxt  = ST_SCAN;
            end
            default: begin
              // unused op code: drop the word
            end
          endcase
        end
      end

      ST_SCAN: begin
        if (!stall) begin
          if (hit_ack) begin
            valid_nxt[eval_idx_r] = 1'b0;
          end
          if (hit_tmo) begin
            mem_we    = 1'b1;
            mem_waddr = eval_idx_r;
            mem_wdata = {ent_seq, now_r};
            // release the held request, it is not the final one
            if (pend_v_r) begin
              out_valid_nxt = 1'b1;
              out_kind_nxt  = pend_kind_r;
              out_seq_nxt   = pend_seq_r;
              out_slot_nxt  = pend_slot_r;
              out_new_nxt   = pend_new_r;
              out_ack_nxt   = pend_ack_r;
              out_mask_nxt  = pend_mask_r;
              out_last_nxt  = 1'b0;
            end
            pend_kind_nxt = KIND_RETX;
            pend_seq_nxt  = ent_seq;
            pend_slot_nxt = SLOT_W'(eval_idx_r);
            pend_new_nxt  = 1'b0;
            pend_ack_nxt  = '0;
            pend_mask_nxt = '0;
            pend_v_nxt    = 1'b1;
          end
          if (issue_r < CNT_W'(WINDOW_SIZE)) begin
            mem_re       = 1'b1;
            issue_nxt    = issue_r + CNT_W'(1);
            eval_v_nxt   = 1'b1;
            eval_idx_nxt = issue_r[IDX_W-1:0];
          end else begin
            eval_v_nxt = 1'b0;
            state_nxt  = ST_FINISH;
          end
        end
      end

      ST_FINISH: begin
        if (!pend_v_r) begin
          state_nxt = ST_IDLE;
        end else if (out_free) begin
          out_valid_nxt = 1'b1;
          out_kind_nxt  = pend_kind_r;
          out_seq_nxt   = pend_seq_r;
          out_slot_nxt  = pend_slot_r;
          out_new_nxt   = pend_new_r;
          out_ack_nxt   = pend_ack_r;
          out_mask_nxt  = pend_mask_r;
          out_last_nxt  = 1'b1;
          pend_v_nxt    = 1'b0;
          state_nxt     = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_data_r <= mem[mem_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      tx_seq_r    <= '0;
      next_slot_r <= '0;
      valid_r     <= '0;
      newest_r    <= '0;
      rmask_r     <= '0;
      any_r       <= 1'b0;
      timeout_r   <= TIMEOUT_RST;
      issue_r     <= '0;
      eval_v_r    <= 1'b0;
      pend_v_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      tx_seq_r    <= tx_seq_nxt;
      next_slot_r <= next_slot_nxt;
      valid_r     <= valid_nxt;
      newest_r    <= newest_nxt;
      rmask_r     <= rmask_nxt;
      any_r       <= any_nxt;
      timeout_r   <= timeout_nxt;
      issue_r     <= issue_nxt;
      eval_v_r    <= eval_v_nxt;
      pend_v_r    <= pend_v_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r        <= op_nxt;
    now_r       <= now_nxt;
    rack_r      <= rack_nxt;
    rackm_r     <= rackm_nxt;
    eval_idx_r  <= eval_idx_nxt;
    pend_kind_r <= pend_kind_nxt;
    pend_seq_r  <= pend_seq_nxt;
    pend_slot_r <= pend_slot_nxt;
    pend_new_r  <= pend_new_nxt;
    pend_ack_r  <= pend_ack_nxt;
    pend_mask_r <= pend_mask_nxt;
    out_kind_r  <= out_kind_nxt;
    out_seq_r   <= out_seq_nxt;
    out_slot_r  <= out_slot_nxt;
    out_new_r   <= out_new_nxt;
    out_ack_r   <= out_ack_nxt;
    out_mask_r  <= out_mask_nxt;
    out_last_r  <= out_last_nxt;
  end

`ifndef SYNTHESIS
  a_idle_no_pending: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE) |-> !pend_v_r)
    else $error("held result left behind on return to idle");

  a_slot_tracks_seq: assert property (@(posedge clk) disable iff (!rst_n)
    32'(next_slot_r) == (32'(tx_seq_r) % WINDOW_SIZE))
    else $error("next slot out of step with next sequence");

  a_send_advances: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && (in_ch.op == OP_SEND)) |=> (tx_seq_r == $past(tx_seq_r) + SEQ_W'(1)))
    else $error("send did not advance the sequence");

  a_finish_drained: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_FINISH) |-> !eval_v_r)
    else $error("scan left an entry unevaluated");
`endif

endmodule
